### sv/tbdl_pkg.sv
// Package with shared constants and types for the timer bank due list.
package tbdl_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int SLOT_W = 4;
    localparam int TICK_W = 64;
    localparam int MASK_W = 16;

    localparam logic [1:0] CMD_ARM    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Slot data that travels along the list of cells
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [TICK_W-1:0] due;
        logic [TICK_W-1:0] per;
    } entry_t;

endpackage

### sv/tbdl_cell.sv
// One list cell: holds one armed slot and shifts toward the head on removal.
module tbdl_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  tbdl_pkg::entry_t load_val,
    output tbdl_pkg::entry_t q
);
    import tbdl_pkg::*;

    entry_t e_reg;

    assign q = e_reg;

    // Capture new contents when told
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_reg <= '0;
        end
        else if (load)
        begin
            e_reg <= load_val;
        end
    end

endmodule

### sv/timer_bank_due_list_top.sv
// Top level of the timer bank due list.
// The armed timers sit in a row of cells in arming order, the head at cell 0, each cell
// holding slot, due tick and period. Arm and cancel pass through the accept cycle, a
// remove pass that closes the gap by shifting every later cell one place toward the
// head, then, for an arm only, an append at the tail. A tick walks the list as it stood
// on arrival, one cell per cycle; each expiry leaves as one result, and the walk waits
// while the result register is full and not taken.
module timer_bank_due_list_top
#(
    parameter int NUM_TIMERS = tbdl_pkg::NUM_TIMERS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [199:0] s_tdata,  // cmd[1:0], slot[5:2], delay[69:6], repeat_period[133:70],
                                   // now[197:134], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // fired_slot[3:0], signaled_mask[19:4], zero fill
    output logic        m_tlast    // last
);
    import tbdl_pkg::*;

    localparam int N   = NUM_TIMERS;
    localparam int IW  = (N > 1) ? $clog2(N) : 1;
    localparam int CW  = $clog2(N + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_REMOVE, ST_APPEND, ST_SCAN} state_t;

    state_t            state_reg;
    logic [1:0]        cmd_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [TICK_W-1:0] delay_reg, per_reg, now_reg;
    logic [N-1:0]      sig_reg;
    logic [CW-1:0]     cnt_reg;      // armed entries
    logic [CW-1:0]     pos_reg;      // scan position
    logic [CW-1:0]     left_reg;     // snapshot entries still to visit
    logic [4:0]        fires_reg;
    logic              pend_reg;     // a fired result waits for the next hit or the end
    logic [SLOT_W-1:0] pend_slot_reg;
    logic [MASK_W-1:0] pend_mask_reg;
    logic              ov_reg;
    logic [SLOT_W-1:0] o_slot_reg;
    logic [MASK_W-1:0] o_mask_reg;
    logic              o_last_reg;

    entry_t cell_q   [N];
    entry_t cell_d   [N];
    logic   cell_ld  [N];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            tbdl_cell u_cell (.clk(clk), .rst_n(rst_n), .load(cell_ld[g]),
                              .load_val(cell_d[g]), .q(cell_q[g]));
        end
    endgenerate

    logic [1:0]        in_cmd;
    logic [SLOT_W-1:0] in_slot;
    assign in_cmd  = s_tdata[1:0];
    assign in_slot = s_tdata[5:2];

    // Locate the slot in the list: one match per cell, prefix gives the shift cells
    logic [N-1:0] hit;
    logic [N-1:0] at_or_after;
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            hit[i] = (CW'(i) < cnt_reg) && (cell_q[i].slot == slot_reg);
        end
        at_or_after[0] = hit[0];
        for (int i = 1; i < N; i++)
        begin
            at_or_after[i] = at_or_after[i-1] | hit[i];
        end
    end

    entry_t          cur;
    logic            cur_due;
    logic            out_free;
    logic [IW-1:0]   pos_idx;
    assign pos_idx  = pos_reg[IW-1:0];
    assign cur      = cell_q[pos_idx];
    assign cur_due  = !(now_reg < cur.due);
    assign out_free = !ov_reg || m_tready;

    logic scan_step;
    assign scan_step = (state_reg == ST_SCAN) && (left_reg != '0) && (fires_reg != 5'd16)
                       && (!pend_reg || !cur_due || out_free);

    logic [N-1:0] sig_after;
    always_comb
    begin
        sig_after = sig_reg;
        sig_after[cur.slot[IW-1:0]] = 1'b1;
    end

    // Cell loads
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            cell_ld[i] = 1'b0;
            cell_d[i]  = cell_q[i];
            if (state_reg == ST_REMOVE && at_or_after[i])
            begin
                cell_ld[i] = 1'b1;
                cell_d[i]  = (i + 1 < N) ? cell_q[(i + 1) % N] : cell_q[i];
            end
            else if (state_reg == ST_APPEND && cmd_reg == CMD_ARM && CW'(i) == cnt_reg)
            begin
                cell_ld[i]    = 1'b1;
                cell_d[i].slot = slot_reg;
                cell_d[i].due  = now_reg + ((delay_reg == '0) ? TICK_W'(1) : delay_reg);
                cell_d[i].per  = per_reg;
            end
            else if (scan_step && cur_due)
            begin
                // Shift cells after pos toward the head, re-armed entry at new tail if it has a period
                if (CW'(i) >= pos_reg && CW'(i) + CW'(1) < cnt_reg)
                begin
                    cell_ld[i] = 1'b1;
                    cell_d[i]  = cell_q[(i + 1) % N];
                end
                else if (CW'(i) + CW'(1) == cnt_reg && cur.per != '0)
                begin
                    cell_ld[i]    = 1'b1;
                    cell_d[i]     = cur;
                    cell_d[i].due = now_reg + cur.per;
                end
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'b0, o_mask_reg, o_slot_reg};
    assign m_tlast  = o_last_reg;

    logic in_range;
    assign in_range = ({1'b0, in_slot} < (SLOT_W+1)'(N)) || (N > 16);

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            slot_reg  <= in_slot;
            delay_reg <= s_tdata[69:6];
            per_reg   <= s_tdata[133:70];
            now_reg   <= s_tdata[197:134];
        end
    end

    logic [MASK_W-1:0] mask16;
    always_comb
    begin
        mask16 = '0;
        for (int i = 0; i < N && i < MASK_W; i++)
        begin
            mask16[i] = sig_after[i];
        end
    end

    // Control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_ARM;
            sig_reg   <= '0;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            left_reg  <= '0;
            fires_reg <= '0;
            pend_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            pend_slot_reg <= '0;
            pend_mask_reg <= '0;
            o_slot_reg <= '0;
            o_mask_reg <= '0;
            o_last_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && m_tready)
            begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg <= in_cmd;
                        if ((in_cmd == CMD_ARM || in_cmd == CMD_CANCEL) && in_range)
                        begin
                            state_reg <= ST_REMOVE;
                        end
                        else if (in_cmd == CMD_TICK)
                        begin
                            state_reg <= ST_SCAN;
                            pos_reg   <= '0;
                            left_reg  <= cnt_reg;
                            fires_reg <= '0;
                            pend_reg  <= 1'b0;
                        end
                    end
                end
                ST_REMOVE:
                begin
                    if (|hit)
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                    sig_reg[slot_reg[IW-1:0]] <= 1'b0;
                    state_reg <= ST_APPEND;
                end
                ST_APPEND:
                begin
                    if (cmd_reg == CMD_ARM)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    state_reg <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    if (scan_step)
                    begin
                        left_reg <= left_reg - CW'(1);
                        if (cur_due)
                        begin
                            sig_reg   <= sig_after;
                            fires_reg <= fires_reg + 5'd1;
                            if (cur.per == '0)
                            begin
                                cnt_reg <= cnt_reg - CW'(1);
                            end
                            pend_reg      <= 1'b1;
                            pend_slot_reg <= cur.slot;
                            pend_mask_reg <= mask16;
                            if (pend_reg)
                            begin
                                ov_reg     <= 1'b1;
                                o_slot_reg <= pend_slot_reg;
                                o_mask_reg <= pend_mask_reg;
                                o_last_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            pos_reg <= pos_reg + CW'(1);
                        end
                    end
                    else if (!scan_step && (left_reg == '0 || fires_reg == 5'd16))
                    begin
                        if (!pend_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (out_free)
                        begin
                            ov_reg     <= 1'b1;
                            o_slot_reg <= pend_slot_reg;
                            o_mask_reg <= pend_mask_reg;
                            o_last_reg <= 1'b1;
                            pend_reg   <= 1'b0;
                            state_reg  <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### dv/tb.sv
// Testbench for the timer bank due list: directed table, then random requests checked by a predictor.
`timescale 1ns / 1ps

module tb;
    import tbdl_pkg::*;

    localparam int NSLOT    = 16;
    localparam int MAX_FIRE = 16;
    localparam int DRAIN    = 60;

    typedef struct {
        logic [1:0]  cmd;
        logic [3:0]  slot;
        logic [63:0] delay;
        logic [63:0] per;
        logic [63:0] now;
        bit          typed;
        logic [3:0]  t_slot;
        logic        t_last;
        logic [15:0] t_mask;
    } req_t;

    typedef struct {
        logic [3:0]  slot;
        logic        last;
        logic [15:0] mask;
    } expiry_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;   // cmd, slot, delay, repeat_period, now, zero fill
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;   // fired_slot, signaled_mask, zero fill
    logic         m_tlast;   // last

    // predictor state
    bit          armed [NSLOT];
    logic [63:0] due_at [NSLOT];
    logic [63:0] period [NSLOT];
    bit          signaled [NSLOT];
    int          arm_list [$];
    expiry_t     expiry_q [$];

    int          fail_cnt;
    int          rx_hold;
    bit          tx_fast;
    bit          rx_fast;
    logic [63:0] cur_now;
    req_t        dir_tab [$];

    timer_bank_due_list_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    // end the run if the block hangs
    initial
    begin
        #20ms;
        $display("timer_bank_due_list_top test failed");
        $finish;
    end

    function automatic logic [15:0] signaled_bits();
        logic [15:0] m;
        m = '0;
        for (int i = 0; i < NSLOT; i++)
            m[i] = signaled[i];
        return m;
    endfunction

    function automatic void drop_from_list(int s);
        for (int i = 0; i < arm_list.size(); i++)
        begin
            if (arm_list[i] == s)
            begin
                arm_list.delete(i);
                return;
            end
        end
    endfunction

    // advance the timer bank by one accepted request, queue the expiries it causes
    function automatic void predict_expiries(req_t r);
        int snap [$];
        int cnt;
        int t;
        expiry_t e;
        cnt = 0;
        case (r.cmd)
            CMD_ARM, CMD_CANCEL:
            begin
                if (armed[r.slot])
                begin
                    drop_from_list(int'(r.slot));
                    armed[r.slot] = 0;
                end
                signaled[r.slot] = 0;
                if (r.cmd == CMD_ARM)
                begin
                    due_at[r.slot] = r.now + ((r.delay != 0) ? r.delay : 64'd1);
                    period[r.slot] = r.per;
                    armed[r.slot] = 1;
                    arm_list.push_back(int'(r.slot));
                end
            end
            CMD_TICK:
            begin
                snap = arm_list;
                foreach (snap[i])
                begin
                    t = snap[i];
                    if (cnt >= MAX_FIRE)
                        break;
                    if (!armed[t] || r.now < due_at[t])
                        continue;
                    drop_from_list(t);
                    armed[t] = 0;
                    signaled[t] = 1;
                    if (period[t] != 0)
                    begin
                        due_at[t] = r.now + period[t];
                        armed[t] = 1;
                        arm_list.push_back(t);
                    end
                    e.slot = 4'(t);
                    e.last = 0;
                    e.mask = signaled_bits();
                    expiry_q.push_back(e);
                    cnt++;
                end
                if (cnt > 0)
                    expiry_q[expiry_q.size()-1].last = 1'b1;
            end
            default: ;
        endcase
        // a hand-written expectation replaces the predicted one
        if (r.typed)
        begin
            repeat (cnt) void'(expiry_q.pop_back());
            e.slot = r.t_slot;
            e.last = r.t_last;
            e.mask = r.t_mask;
            expiry_q.push_back(e);
        end
    endfunction

    function automatic req_t mk(logic [1:0] cmd, logic [3:0] slot, logic [63:0] delay,
                                logic [63:0] per, logic [63:0] now);
        req_t r;
        r.cmd = cmd; r.slot = slot; r.delay = delay; r.per = per; r.now = now;
        r.typed = 0; r.t_slot = '0; r.t_last = 0; r.t_mask = '0;
        return r;
    endfunction

    function automatic req_t mk_typed(logic [3:0] slot, logic [63:0] now,
                                      logic [3:0] t_slot, logic [15:0] t_mask);
        req_t r;
        r = mk(CMD_TICK, slot, '0, '0, now);
        r.typed = 1; r.t_slot = t_slot; r.t_last = 1'b1; r.t_mask = t_mask;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random request around a slowly advancing clock count
    function automatic req_t rand_req();
        int k;
        logic [63:0] d;
        logic [63:0] p;
        logic [1:0]  c;
        k = int'($urandom_range(99));
        c = (k < 40) ? CMD_ARM : (k < 50) ? CMD_CANCEL : (k < 96) ? CMD_TICK : CMD_UNUSED;
        k = int'($urandom_range(99));
        d = (k < 70) ? 64'($urandom_range(6)) : (k < 85) ? rand64()
                     : ~64'($urandom_range(6));
        k = int'($urandom_range(99));
        p = (k < 50) ? 64'd0 : (k < 85) ? 64'($urandom_range(8, 1)) : rand64();
        if ($urandom_range(99) < 5)
            cur_now = rand64();
        else
            cur_now = cur_now + 64'($urandom_range(4));
        return mk(c, 4'($urandom_range(15)), d, p, cur_now);
    endfunction

    // offer one request and hold it until accepted
    task automatic send_req(req_t r);
        int gap;
        gap = tx_fast ? 0 : int'($urandom_range(16));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b0, r.now, r.per, r.delay, r.slot, r.cmd};
        do @(posedge clk); while (!s_tready);
        predict_expiries(r);
    endtask

    // let every expected result arrive, then allow the block to settle
    task automatic drain_bank();
        s_tvalid <= 1'b0;
        wait (expiry_q.size() == 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    // receive side: random stalls, plus the long hold when one is asked for
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int w;
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            else
            begin
                w = rx_fast ? 0 : int'($urandom_range(16));
                if (w > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (w) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // compare each delivered expiry with the oldest one predicted
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expiry_q.size() == 0)
            begin
                $error("unexpected expiry: slot %0d", m_tdata[3:0]);
                fail_cnt++;
            end
            else
            begin
                expiry_t e;
                e = expiry_q.pop_front();
                if (m_tdata[3:0] !== e.slot)
                begin
                    $error("fired_slot: expected %0d, got %0d", e.slot, m_tdata[3:0]);
                    fail_cnt++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, m_tlast);
                    fail_cnt++;
                end
                if (m_tdata[19:4] !== e.mask)
                begin
                    $error("signaled_mask: expected %h, got %h", e.mask, m_tdata[19:4]);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        fail_cnt = 0;
        rx_hold = 0;
        tx_fast = 0;
        rx_fast = 0;
        cur_now = 64'd100;
        for (int i = 0; i < NSLOT; i++)
        begin
            armed[i] = 0; signaled[i] = 0; due_at[i] = '0; period[i] = '0;
        end

        // directed requests: empty tick, delay zero, wrapping due and period, ignored code
        dir_tab.push_back(mk(CMD_TICK, 4'd0, '0, '0, '0));
        dir_tab.push_back(mk(CMD_ARM, 4'd0, '0, '0, '0));
        dir_tab.push_back(mk(CMD_TICK, 4'd0, '0, '0, '0));
        dir_tab.push_back(mk_typed(4'd0, 64'd1, 4'd0, 16'h0001));
        dir_tab.push_back(mk(CMD_CANCEL, 4'd0, '0, '0, 64'd1));
        dir_tab.push_back(mk(CMD_ARM, 4'd15, '1, '1, 64'd5));
        dir_tab.push_back(mk_typed(4'd0, 64'd5, 4'd15, 16'h8000));
        dir_tab.push_back(mk(CMD_TICK, 4'd15, '1, '1, 64'd5));
        dir_tab.push_back(mk(CMD_CANCEL, 4'd15, '1, '1, '1));
        dir_tab.push_back(mk(CMD_UNUSED, 4'd9, '1, '1, '1));
        dir_tab.push_back(mk(CMD_ARM, 4'd7, 64'd1, '0, '1));
        dir_tab.push_back(mk(CMD_ARM, 4'd3, 64'd2, 64'd1, '0));
        dir_tab.push_back(mk(CMD_ARM, 4'd5, 64'd1, 64'd3, '0));
        dir_tab.push_back(mk(CMD_ARM, 4'd3, 64'd1, 64'd2, '0));
        dir_tab.push_back(mk(CMD_TICK, 4'd0, '0, '0, '1));
        dir_tab.push_back(mk(CMD_CANCEL, 4'd5, '0, '0, '0));
        dir_tab.push_back(mk(CMD_CANCEL, 4'd3, '0, '0, '0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_req(dir_tab[i]);
        drain_bank();

        // fill the bank, then hold the receiver while ticks keep coming
        tx_fast = 1;
        for (int s = 0; s < NSLOT; s++)
            send_req(mk(CMD_ARM, 4'(s), 64'd1, 64'd1, cur_now));
        rx_hold = 400;
        repeat (3)
        begin
            cur_now = cur_now + 64'd1;
            send_req(mk(CMD_TICK, 4'd0, '0, '0, cur_now));
        end
        drain_bank();
        for (int s = 0; s < NSLOT; s++)
            send_req(mk(CMD_CANCEL, 4'(s), '0, '0, cur_now));
        drain_bank();

        // random phases with changing idle behavior
        for (int ph = 0; ph < 4; ph++)
        begin
            tx_fast = (ph == 1);
            rx_fast = (ph == 2);
            repeat (20)
                send_req(rand_req());
            drain_bank();
        end

        if (fail_cnt == 0)
            $display("timer_bank_due_list_top test passed");
        else
            $display("timer_bank_due_list_top test failed");
        $finish;
    end

endmodule

### timer_bank_due_list_top.f
sv/tbdl_pkg.sv
sv/tbdl_cell.sv
sv/timer_bank_due_list_top.sv
dv/tb.sv
